/* src/eip_pkg.sv */
// ----------------------------------------------------------------------------
// eip_pkg
// Shared widths, constants and types of the eleven-point interpolated
// average precision block.
// ----------------------------------------------------------------------------
`default_nettype none

package eip_pkg;

  // List length bound and recall level count
  localparam int unsigned MAX_LIST_LEN      = 1048576;
  localparam int unsigned RECALL_LEVELS_DEF = 11;
  localparam int unsigned RECALL_LEVELS_MAX = 21;

  // Field and state widths
  localparam int unsigned WT_W    = 16;
  localparam int unsigned TOT_W   = 32;
  localparam int unsigned SUM_W   = 36;
  localparam int unsigned RANK_W  = $clog2(2 * MAX_LIST_LEN);
  localparam int unsigned PREC_W  = 17;
  localparam int unsigned TALLY_W = 16;

  // Entries of the queue between front and back
  localparam int unsigned Q_DEPTH = 4;

  // Shared divider operand widths, wide enough up to RECALL_LEVELS_MAX levels
  localparam int unsigned RL_MAX_W = $clog2(RECALL_LEVELS_MAX + 1);
  localparam int unsigned DVD_W    = SUM_W + 8;
  localparam int unsigned DVS_W    = (RANK_W > RL_MAX_W + TALLY_W) ? RANK_W
                                                                  : RL_MAX_W + TALLY_W;

  // Saturation limits
  localparam logic [RANK_W-1:0]  RANK_CAP  = RANK_W'(2 * MAX_LIST_LEN - 1);
  localparam logic [SUM_W-1:0]   SUM_CAP   = {SUM_W{1'b1}};
  localparam logic [PREC_W-1:0]  PREC_ONE  = PREC_W'(65536);
  localparam logic [TALLY_W-1:0] TALLY_CAP = {TALLY_W{1'b1}};

  // Input item
  typedef struct packed {
    logic [WT_W-1:0] relevance_weight;
    logic            last_in_list;
  } eip_in_t;

  // Result item
  typedef struct packed {
    logic [PREC_W-1:0]  query_precision;
    logic [PREC_W-1:0]  mean_precision;
    logic               query_counted;
    logic [TALLY_W-1:0] queries_done;
  } eip_out_t;

  // Classified item as it waits for the back end
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [RANK_W-1:0] rank;
    logic [TOT_W-1:0]  total;
    logic              relevant;
    logic              total_pos;
    logic              last;
  } eip_entry_t;

  // Divider request and response
  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } eip_div_req_t;

  typedef struct packed {
    logic              done;
    logic [PREC_W-1:0] quotient;
  } eip_div_rsp_t;

  // Back end sequencer
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_PREC,
    BK_UPDATE,
    BK_SUM,
    BK_QDIV,
    BK_MDIV,
    BK_OUT
  } eip_state_e;

endpackage

`default_nettype wire

/* src/eip_front.sv */
// ----------------------------------------------------------------------------
// eip_front
// Accepts ranked documents, keeps rank and relevant sum of the current
// query and pushes one classified entry per document into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module eip_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  eip_pkg::eip_in_t             in_data_i,
  input  logic                         cfg_we_i,
  input  logic [eip_pkg::TOT_W-1:0]    cfg_wdata_i,
  input  logic                         q_full_i,
  output logic                         q_push_o,
  output eip_pkg::eip_entry_t          q_entry_o
);
  import eip_pkg::*;

  logic [TOT_W-1:0]  total_q;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  logic [SUM_W:0]    sum_add;
  logic              relevant;
  logic              accept;

  // Stall only on a full queue
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  // Classify and advance rank and saturating sum
  assign relevant = (total_q != '0) && (in_data_i.relevance_weight != '0);
  assign sum_add  = {1'b0, sum_q} + (SUM_W + 1)'(in_data_i.relevance_weight);
  assign rank_d   = (rank_q < RANK_CAP) ? rank_q + 1'b1 : rank_q;

  always_comb begin
    sum_d = sum_q;
    if (relevant) begin
      sum_d = sum_add[SUM_W] ? SUM_CAP : sum_add[SUM_W-1:0];
    end
  end

  // Build the queue entry
  always_comb begin
    q_entry_o.sum       = sum_d;
    q_entry_o.rank      = rank_d;
    q_entry_o.total     = total_q;
    q_entry_o.relevant  = relevant;
    q_entry_o.total_pos = (total_q != '0);
    q_entry_o.last      = in_data_i.last_in_list;
  end

  // Hold the total relevance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  // Update per-query counters, drop them after the last document
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      rank_q <= '0;
    end else if (accept) begin
      if (in_data_i.last_in_list) begin
        sum_q  <= '0;
        rank_q <= '0;
      end else begin
        sum_q  <= sum_d;
        rank_q <= rank_d;
      end
    end
  end

endmodule

`default_nettype wire

/* src/eip_fifo.sv */
// ----------------------------------------------------------------------------
// eip_fifo
// Short queue of classified entries between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module eip_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  eip_pkg::eip_entry_t  entry_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output eip_pkg::eip_entry_t  head_o
);
  import eip_pkg::*;

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  eip_entry_t       mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(Q_DEPTH))
    else $error("queue fill count above depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue push lost");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

/* src/eip_div.sv */
// ----------------------------------------------------------------------------
// eip_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller keeps
// the quotient below 2**PREC_W.
// ----------------------------------------------------------------------------
`default_nettype none

module eip_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  eip_pkg::eip_div_req_t req_i,
  output eip_pkg::eip_div_rsp_t rsp_o
);
  import eip_pkg::*;

  localparam int unsigned CMP_W = (DVD_W > DVS_W + PREC_W - 1) ? DVD_W
                                                              : DVS_W + PREC_W - 1;
  localparam int unsigned CNT_W = $clog2(PREC_W + 1);

  logic [CMP_W-1:0]  rem_q, dsh_q;
  logic [PREC_W-1:0] quo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic              ge;

  assign ge = (rem_q >= dsh_q);

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  // Load operands, then subtract the shifted divisor one bit a cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= CMP_W'(req_i.dividend);
      dsh_q <= CMP_W'(req_i.divisor) << (PREC_W - 1);
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[PREC_W-2:0], ge};
    end
  end

  // Count steps and flag completion
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(PREC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

/* src/eip_back.sv */
// ----------------------------------------------------------------------------
// eip_back
// Takes classified entries from the queue, works out precision and recall
// levels reached, keeps the per-level maxima and forms the query result.
// ----------------------------------------------------------------------------
`default_nettype none

module eip_back #(
  parameter int unsigned RECALL_LEVELS = eip_pkg::RECALL_LEVELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  eip_pkg::eip_entry_t  q_head_i,
  output logic                 q_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output eip_pkg::eip_out_t    out_data_o
);
  import eip_pkg::*;

  localparam int unsigned K_W    = $clog2(RECALL_LEVELS + 1);
  localparam int unsigned KI_W   = $clog2(RECALL_LEVELS);
  localparam int unsigned LHS_W  = SUM_W + $clog2(RECALL_LEVELS);
  localparam int unsigned RHS_W  = TOT_W + $clog2(RECALL_LEVELS);
  localparam int unsigned LSUM_W = $clog2(RECALL_LEVELS * 65536 + 1);
  localparam int unsigned QT_W   = LSUM_W + TALLY_W;
  // Reciprocal of the level count, exact floor for every level sum
  localparam int unsigned QREC_S = LSUM_W + $clog2(RECALL_LEVELS);
  localparam int unsigned QPRD_W = LSUM_W + QREC_S;
  localparam logic [QREC_S-1:0] QREC_M =
    QREC_S'(((64'd1 << QREC_S) + 64'(RECALL_LEVELS) - 64'd1) / 64'(RECALL_LEVELS));

  eip_state_e         state_q, state_d;
  logic [K_W-1:0]     k_q;
  logic [KI_W-1:0]    k_idx;
  logic               sweep_done;
  logic [LHS_W-1:0]   lhs_q;
  logic [RHS_W-1:0]   rhs_q;
  logic [TOT_W-1:0]   tot_q;
  logic [RECALL_LEVELS-1:0] mask_q;
  logic               sat_q, last_q, tpos_q, pdone_q;
  logic [PREC_W-1:0]  prec_q;
  logic [PREC_W-1:0]  level_max_q [RECALL_LEVELS];
  logic [LSUM_W-1:0]  acc_q;
  logic [QPRD_W-1:0]  qprod;
  logic [PREC_W-1:0]  qprec_q, mprec_q;
  logic               counted_q;
  logic [TALLY_W-1:0] tally_q;
  logic [QT_W-1:0]    qtotal_q;
  logic               out_valid_q;
  eip_out_t           out_data_q;
  logic               out_free, out_load, counted_d;
  eip_div_req_t       div_req;
  eip_div_rsp_t       div_rsp;

  eip_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign k_idx      = k_q[KI_W-1:0];
  assign sweep_done = (k_q == K_W'(RECALL_LEVELS));
  assign out_free   = !out_valid_q || !out_stall_i;
  assign counted_d  = tpos_q && (tally_q != TALLY_CAP);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Divide the level sum by the level count
  assign qprod = QPRD_W'(acc_q) * QPRD_W'(QREC_M);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_empty_i) begin
          if (q_head_i.relevant) begin
            state_d = BK_PREC;
          end else if (q_head_i.last) begin
            state_d = BK_SUM;
          end
        end
      end
      BK_PREC: begin
        if (pdone_q && sweep_done) state_d = BK_UPDATE;
      end
      BK_UPDATE: begin
        state_d = last_q ? BK_SUM : BK_IDLE;
      end
      BK_SUM: begin
        if (sweep_done) state_d = BK_QDIV;
      end
      BK_QDIV: begin
        state_d = (tally_q == '0) ? BK_OUT : BK_MDIV;
      end
      BK_MDIV: begin
        if (div_rsp.done) state_d = BK_OUT;
      end
      BK_OUT: begin
        if (out_free) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Queue pop, divider requests and output load
  always_comb begin
    q_pop_o          = 1'b0;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DVD_W'({q_head_i.sum, 8'b0});
    div_req.divisor  = DVS_W'(q_head_i.rank);
    unique case (state_q)
      BK_IDLE: begin
        q_pop_o       = !q_empty_i;
        div_req.start = !q_empty_i && q_head_i.relevant;
      end
      BK_QDIV: begin
        div_req.start    = (tally_q != '0);
        div_req.dividend = DVD_W'(qtotal_q);
        div_req.divisor  = DVS_W'(RECALL_LEVELS) * DVS_W'(tally_q);
      end
      BK_OUT: begin
        out_load = out_free;
      end
      default: begin
        q_pop_o = 1'b0;
      end
    endcase
  end

  // Sequencer, level maxima, query totals and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      k_q         <= '0;
      pdone_q     <= 1'b0;
      tally_q     <= '0;
      qtotal_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < RECALL_LEVELS; i++) begin
        level_max_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      unique case (state_q)
        BK_IDLE: begin
          k_q     <= '0;
          pdone_q <= 1'b0;
        end
        BK_PREC: begin
          if (!sweep_done) k_q <= k_q + 1'b1;
          if (div_rsp.done) pdone_q <= 1'b1;
        end
        BK_UPDATE: begin
          k_q <= '0;
          for (int i = 0; i < RECALL_LEVELS; i++) begin
            if (mask_q[i] && (level_max_q[i] < prec_q)) begin
              level_max_q[i] <= prec_q;
            end
          end
        end
        BK_SUM: begin
          if (!sweep_done) begin
            k_q <= k_q + 1'b1;
          end else if (counted_d) begin
            qtotal_q <= qtotal_q + QT_W'(acc_q);
            tally_q  <= tally_q + 1'b1;
          end
        end
        BK_OUT: begin
          if (out_free) begin
            for (int i = 0; i < RECALL_LEVELS; i++) begin
              level_max_q[i] <= '0;
            end
          end
        end
        default: begin
          k_q <= k_q;
        end
      endcase
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Operand capture, recall sweep, level sum and result fields
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      BK_IDLE: begin
        lhs_q  <= LHS_W'(RECALL_LEVELS - 1) * LHS_W'(q_head_i.sum);
        rhs_q  <= '0;
        tot_q  <= q_head_i.total;
        sat_q  <= q_head_i.sum >= SUM_W'({q_head_i.rank, 8'b0});
        last_q <= q_head_i.last;
        tpos_q <= q_head_i.total_pos;
        acc_q  <= '0;
      end
      BK_PREC: begin
        if (!sweep_done) begin
          mask_q[k_idx] <= (lhs_q >= LHS_W'(rhs_q));
          rhs_q         <= rhs_q + RHS_W'(tot_q);
        end
        if (div_rsp.done) begin
          prec_q <= sat_q ? PREC_ONE : div_rsp.quotient;
        end
      end
      BK_UPDATE: begin
        acc_q <= '0;
      end
      BK_SUM: begin
        if (!sweep_done) begin
          acc_q <= acc_q + LSUM_W'(level_max_q[k_idx]);
        end else begin
          counted_q <= counted_d;
        end
      end
      BK_QDIV: begin
        qprec_q <= PREC_W'(qprod >> QREC_S);
        mprec_q <= '0;
      end
      BK_MDIV: begin
        if (div_rsp.done) mprec_q <= div_rsp.quotient;
      end
      BK_OUT: begin
        if (out_free) begin
          out_data_q.query_precision <= qprec_q;
          out_data_q.mean_precision  <= mprec_q;
          out_data_q.query_counted   <= counted_q;
          out_data_q.queries_done    <= tally_q;
        end
      end
      default: begin
        acc_q <= acc_q;
      end
    endcase
  end

  a_tally_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tally_q != $past(tally_q) |-> tally_q == $past(tally_q) + 1'b1)
    else $error("query tally moved by more than one");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == BK_PREC) || (state_q == BK_QDIV) ||
                     (state_q == BK_MDIV))
    else $error("divider finished outside a divide state");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (out_data_q.query_precision <= PREC_ONE) &&
                 (state_q == BK_IDLE))
    else $error("result not presented after load");

endmodule

`default_nettype wire

/* src/eleven_point_interp_precision.sv */
// ----------------------------------------------------------------------------
// eleven_point_interp_precision
// Eleven-point interpolated average precision over ranked document lists.
// ----------------------------------------------------------------------------
// Feed the relevance weight of each document of one query in rank order and
// flag the last one; write total_relevance (Q24.8) before the query starts.
// A front end takes one document per cycle into a four-entry queue, so the
// input stalls only when the queue is full. The back end retires an
// irrelevant document as it pops it; a relevant one is popped, then the
// 17-step radix-2 divider forms sum/rank while the recall levels are tested
// one per cycle, and then the level maxima are raised. For the last
// document the back end sums the level maxima, forms the query mean,
// divides the running mean once any query is counted, and loads the result
// register, which then waits for the consumer while new documents keep
// entering.
// ----------------------------------------------------------------------------
`default_nettype none

module eleven_point_interp_precision #(
  parameter int unsigned RECALL_LEVELS = eip_pkg::RECALL_LEVELS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  eip_pkg::eip_in_t          in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output eip_pkg::eip_out_t         out_data_o,
  input  logic                      cfg_we_i,
  input  logic [eip_pkg::TOT_W-1:0] cfg_wdata_i
);
  import eip_pkg::*;

  logic       q_push, q_full, q_pop, q_empty;
  eip_entry_t q_entry, q_head;

  // Accept and classify documents
  eip_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_entry)
  );

  // Decouple front and back
  eip_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .head_o  (q_head)
  );

  // Precision, level maxima and query results
  eip_back #(
    .RECALL_LEVELS (RECALL_LEVELS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench for eleven_point_interp_precision. A short table of documents and
// total_relevance writes covers the extremes, then random ranked lists follow,
// with random stall bursts on both channels. Every result is checked field by
// field against the typed outcome of its table row or a local score predictor.
// ----------------------------------------------------------------------------

module tb;

  import eip_pkg::*;

  localparam int unsigned NUM_LEVELS   = RECALL_LEVELS_DEF;
  localparam int unsigned RANDOM_DOCS  = 1100;
  localparam int unsigned QUIET_TAIL   = 150;
  // Longest back end work left after the last result: a full queue of
  // relevant documents plus the closing steps of a query
  localparam int unsigned DRAIN_CYCLES = 160;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned DIR_ROWS     = 23;

  typedef enum logic {
    ROW_CFG,
    ROW_DOC
  } row_kind_e;

  typedef struct packed {
    row_kind_e       kind;
    logic [TOT_W-1:0] value;
    logic            last;
    logic            typed;
    eip_out_t        outcome;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  eip_in_t             in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  eip_out_t            out_data_o;
  logic                cfg_we_i;
  logic [TOT_W-1:0]    cfg_wdata_i;

  // Predictor state
  logic [TOT_W-1:0]    cur_total;
  logic [SUM_W-1:0]    rel_sum;
  logic [RANK_W-1:0]   doc_rank;
  logic [PREC_W-1:0]   level_best [NUM_LEVELS];
  logic [36:0]         prec_total;
  logic [TALLY_W-1:0]  counted_queries;

  eip_out_t            expected_scores [$];
  eip_out_t            want;
  logic [WT_W-1:0]     doc_weights [$];
  int unsigned         err_count;
  int unsigned         cycle_count;
  bit                  tail_quiet;
  bit                  in_idle_en;
  bit                  out_idle_en;

  // Directed rows: typed outcomes only where they are obvious
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{ROW_CFG, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_FFFF, 1'b1, 1'b1, '{17'd0, 17'd0, 1'b0, 16'd0}},
    '{ROW_CFG, 32'h0000_0100, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_0100, 1'b1, 1'b1, '{17'd65536, 17'd65536, 1'b1, 16'd1}},
    '{ROW_DOC, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_0100, 1'b1, 1'b0, '0},
    '{ROW_CFG, 32'hFFFF_FFFF, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_FFFF, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_FFFF, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_FFFF, 1'b1, 1'b0, '0},
    '{ROW_DOC, 32'h0000_0000, 1'b1, 1'b0, '0},
    '{ROW_CFG, 32'h0000_0300, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_0100, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_0100, 1'b0, 1'b0, '0},
    // total changed in the middle of a query
    '{ROW_CFG, 32'h0000_0180, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_0080, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_FFFF, 1'b1, 1'b0, '0},
    '{ROW_CFG, 32'h0000_0001, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_0001, 1'b1, 1'b0, '0},
    '{ROW_CFG, 32'h0000_1000, 1'b0, 1'b0, '0},
    '{ROW_DOC, 32'h0000_FFFF, 1'b1, 1'b0, '0}
  };

  eleven_point_interp_precision dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Clear the per-query scores
  function automatic void clear_query_scores();
    rel_sum  = '0;
    doc_rank = '0;
    foreach (level_best[k]) level_best[k] = '0;
  endfunction

  // Score one document; return 1 when it closes a query and fill the result
  function automatic bit score_doc(input logic [WT_W-1:0] weight, input logic last,
                                   output eip_out_t res);
    longint unsigned wide_sum;
    longint unsigned prec;
    longint unsigned level_sum;
    longint unsigned mean;
    bit              counted;
    res = '0;
    counted = 1'b0;
    level_sum = 0;
    if (doc_rank != RANK_CAP) doc_rank = doc_rank + 1'b1;
    if (cur_total != '0 && weight != '0) begin
      wide_sum = 64'(rel_sum) + 64'(weight);
      rel_sum  = (wide_sum > 64'(SUM_CAP)) ? SUM_CAP : wide_sum[SUM_W-1:0];
      prec     = (64'(rel_sum) << 8) / 64'(doc_rank);
      if (prec > 64'(PREC_ONE)) prec = 64'(PREC_ONE);
      for (int k = 0; k < NUM_LEVELS; k++) begin
        if (64'(NUM_LEVELS - 1) * 64'(rel_sum) >= 64'(k) * 64'(cur_total) &&
            64'(level_best[k]) < prec)
          level_best[k] = prec[PREC_W-1:0];
      end
    end
    if (!last) return 1'b0;
    foreach (level_best[k]) level_sum += 64'(level_best[k]);
    if (cur_total != '0 && counted_queries != TALLY_CAP) begin
      prec_total      = prec_total + 37'(level_sum);
      counted_queries = counted_queries + 1'b1;
      counted         = 1'b1;
    end
    mean = (counted_queries == '0) ? 0
         : 64'(prec_total) / (64'(NUM_LEVELS) * 64'(counted_queries));
    res.query_precision = PREC_W'(level_sum / NUM_LEVELS);
    res.mean_precision  = PREC_W'(mean);
    res.query_counted   = counted;
    res.queries_done    = counted_queries;
    clear_query_scores();
    return 1'b1;
  endfunction

  // Write total_relevance once the block has drained
  task automatic write_total(input logic [TOT_W-1:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_scores.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cur_total = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Transfer one document, with an optional gap in front
  task automatic send_doc(input logic [WT_W-1:0] weight, input logic last,
                          input logic typed, input eip_out_t outcome);
    eip_out_t res;
    @(negedge clk_i);
    if (in_idle_en && !tail_quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    in_valid_i                <= 1'b1;
    in_data_i.relevance_weight <= weight;
    in_data_i.last_in_list     <= last;
    do @(posedge clk_i); while (in_stall_o);
    if (score_doc(weight, last, res))
      expected_scores.push_back(typed ? outcome : res);
  endtask

  // Output stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      if (out_idle_en && !tail_quiet && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(negedge clk_i);
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_scores.size() == 0) begin
        $error("result with no expectation: query_precision %0d",
               out_data_o.query_precision);
        err_count++;
      end else begin
        want = expected_scores.pop_front();
        if (out_data_o.query_precision !== want.query_precision) begin
          $error("query_precision: expected %0d, got %0d",
                 want.query_precision, out_data_o.query_precision);
          err_count++;
        end
        if (out_data_o.mean_precision !== want.mean_precision) begin
          $error("mean_precision: expected %0d, got %0d",
                 want.mean_precision, out_data_o.mean_precision);
          err_count++;
        end
        if (out_data_o.query_counted !== want.query_counted) begin
          $error("query_counted: expected %0d, got %0d",
                 want.query_counted, out_data_o.query_counted);
          err_count++;
        end
        if (out_data_o.queries_done !== want.queries_done) begin
          $error("queries_done: expected %0d, got %0d",
                 want.queries_done, out_data_o.queries_done);
          err_count++;
        end
      end
    end
  end

  // Timeout
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Main sequence
  initial begin
    int unsigned      docs_sent;
    int unsigned      nq;
    int unsigned      len;
    int unsigned      pick;
    int unsigned      weight_sum;
    logic [TOT_W-1:0] total;
    logic [WT_W-1:0]  w;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_data_i       = '0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    err_count       = 0;
    cycle_count     = 0;
    tail_quiet      = 1'b0;
    in_idle_en      = 1'b1;
    out_idle_en     = 1'b1;
    docs_sent       = 0;
    cur_total       = '0;
    prec_total      = '0;
    counted_queries = '0;
    clear_query_scores();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_total(dir_rows[i].value);
      else
        send_doc(dir_rows[i].value[WT_W-1:0], dir_rows[i].last,
                 dir_rows[i].typed, dir_rows[i].outcome);
    end

    // Random ranked lists, one total per phase
    while (docs_sent < RANDOM_DOCS) begin
      tail_quiet  = (docs_sent + QUIET_TAIL >= RANDOM_DOCS);
      in_idle_en  = ($urandom_range(0, 3) != 0);
      out_idle_en = ($urandom_range(0, 3) != 0);
      nq = $urandom_range(1, 3);
      for (int q = 0; q < nq; q++) begin
        // Build the list: mostly short, a few long ones
        doc_weights.delete();
        weight_sum = 0;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        repeat (len) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0, 1, 2, 3: w = '0;
            4:          w = 16'hFFFF;
            5:          w = 16'h0100;
            6:          w = WT_W'($urandom_range(1, 255));
            default:    w = WT_W'($urandom_range(0, 65535));
          endcase
          doc_weights.push_back(w);
          weight_sum += w;
        end
        // Pick the total from the first list of the phase
        if (q == 0) begin
          pick = $urandom_range(0, 9);
          case (pick)
            0:       total = '0;
            1:       total = '1;
            2:       total = $urandom();
            3:       total = weight_sum + $urandom_range(1, 600);
            4:       total = (weight_sum > 1) ? weight_sum - $urandom_range(1, weight_sum - 1)
                                              : weight_sum;
            default: total = weight_sum;
          endcase
          write_total(total);
        end
        foreach (doc_weights[i]) begin
          send_doc(doc_weights[i], i == doc_weights.size() - 1, 1'b0, '0);
          docs_sent++;
        end
      end
    end

    // Drain
    tail_quiet = 1'b1;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
